>>> rtl/core/pcarb_pkg.sv
package pcarb_pkg;

  typedef enum logic {
    OP_POINT = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  localparam int unsigned CFG_HALF_FOV  = 0;
  localparam int unsigned CFG_BIN_SCALE = 1;

  localparam int unsigned ATAN_LEN  = 24;
  localparam int unsigned PRE_SHIFT = 12;
  localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;

  // CORDIC vector width: 17-bit magnitude shifted by 12, plus gain headroom.
  localparam int unsigned CW = 32;
  localparam int unsigned AW = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_BIN,
    ST_SQRT,
    ST_READ,
    ST_WRITE,
    ST_CLEAR
  } state_t;

  function automatic logic signed [AW-1:0] atan_q20(input logic [4:0] i);
    logic signed [AW-1:0] r;
    case (i)
      5'd0:  r = 24'sd823550;
      5'd1:  r = 24'sd486170;
      5'd2:  r = 24'sd256879;
      5'd3:  r = 24'sd130396;
      5'd4:  r = 24'sd65451;
      5'd5:  r = 24'sd32757;
      5'd6:  r = 24'sd16383;
      5'd7:  r = 24'sd8192;
      5'd8:  r = 24'sd4096;
      5'd9:  r = 24'sd2048;
      5'd10: r = 24'sd1024;
      5'd11: r = 24'sd512;
      5'd12: r = 24'sd256;
      5'd13: r = 24'sd128;
      5'd14: r = 24'sd64;
      5'd15: r = 24'sd32;
      5'd16: r = 24'sd16;
      5'd17: r = 24'sd8;
      5'd18: r = 24'sd4;
      5'd19: r = 24'sd2;
      5'd20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/pcarb_sqrt.sv
// Bit-serial rounded square root of a 32-bit sum, one result bit per cycle.
module pcarb_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  import pcarb_pkg::*;

  logic [31:0] s;
  logic [16:0] r;
  logic [4:0]  bit_idx;
  logic        busy;
  logic        fin;
  logic [16:0] trial;
  logic [33:0] trial_sq;
  logic [33:0] rem;

  assign trial    = r | (17'd1 << bit_idx);
  assign trial_sq = trial * trial;
  assign rem      = {2'b00, s} - r * r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        fin     <= 1'b0;
        s       <= radicand;
        r       <= '0;
        bit_idx <= 5'd16;
      end else if (busy) begin
        if (trial_sq <= {2'b00, s}) r <= trial;
        if (bit_idx == 5'd0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          bit_idx <= bit_idx - 5'd1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if (rem > {17'd0, r}) begin
          root <= (r + 17'd1 > 17'hFFFF) ? 16'hFFFF : 16'(r + 17'd1);
        end else begin
          root <= (r > 17'hFFFF) ? 16'hFFFF : r[15:0];
        end
      end
    end
  end
endmodule

>>> rtl/core/point_cloud_angular_range_binner.sv
// Point-cloud angular range binner.
// Input channel (in_valid/in_stall): one transaction per point or read request.
//   operation 0: a point; if point_valid and half_fov != 0, its angle
//   atan(x/-z) is found by a CORDIC unit (one step per cycle) and its
//   horizontal range by a bit-serial square root (one bit per cycle). The bin
//   entry in the bin memory is read, compared and written back.
//   operation 1: reads bin read_bin, clears it, and returns one transaction
//   on the output channel (bin_range, bin_echo); out-of-table reads give 0.
// Sequence: a read registers its result in ST_READ, waiting there while the
//   output is stalled, and clears its bin in ST_WRITE. A binned point runs
//   CORDIC_STEPS steps (at most ATAN_LEN, none when x or z is zero), the bin
//   check, the 17-bit square root and rounding, then the read-modify-write.
//   A point outside the table ends after the bin check; an ignored point
//   stays idle. One item is in work at a time; in_stall is high meanwhile.
// Output: a result register holds the transaction while out_stall is high;
//   a next read is accepted meanwhile but completes only once it is free.
// Reset: synchronous; clears state and configuration, then zeroes every bin,
//   one per cycle, with in_stall high. Configuration, write only, by cfg_we,
//   cfg_index, cfg_data; the user must have it taken while idle, unchecked.
module point_cloud_angular_range_binner #(
  parameter int unsigned BIN_COUNT    = 180,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  logic signed [15:0]     x_mm,
  input  logic signed [15:0]     z_mm,
  input  logic                   point_valid,
  input  logic [7:0]             read_bin,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            bin_range,
  output logic [7:0]             bin_echo
);
  import pcarb_pkg::*;

  localparam int unsigned BW    = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int unsigned STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  logic [14:0] half_fov;
  logic [15:0] bin_scale;

  state_t state, state_next;

  logic [15:0] mem [BIN_COUNT];
  logic [15:0] mem_rd;
  logic [BW-1:0] rd_addr;

  logic               is_read;
  logic [7:0]         req_bin;
  logic [BW-1:0]      addr;
  logic               addr_ok;
  logic signed [CW-1:0] cu, cv;
  logic signed [AW-1:0] ang;
  logic [4:0]         step;
  logic               cordic_skip;
  logic [31:0]        sum_sq;
  logic signed [AW-1:0] pos;
  logic [40:0]        prod;
  logic [15:0]        range_val;
  logic               sq_start, sq_done;
  logic [15:0]        sq_root;
  logic [BW:0]        clr_cnt;

  logic accept;
  logic signed [16:0] u0, v0;
  logic signed [CW-1:0] du, dv;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_fov  <= '0;
      bin_scale <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CFG_HALF_FOV)) half_fov <= cfg_data[14:0];
      else bin_scale <= cfg_data;
    end
  end

  // initial vector, negated into right half-plane
  always_comb begin
    u0 = -17'(signed'(z_mm));
    v0 = 17'(signed'(x_mm));
    if (u0 < 0) begin
      u0 = -u0;
      v0 = -v0;
    end
  end

  assign du = cv >>> step;
  assign dv = cu >>> step;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == (BW+1)'(BIN_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_READ) state_next = ST_READ;
          else if (point_valid && half_fov != '0) state_next = ST_ITER;
        end
      end
      ST_ITER: if (step == 5'(STEPS - 1) || cordic_skip) state_next = ST_BIN;
      ST_BIN:  state_next = ST_SQRT;
      ST_SQRT: begin
        if (!addr_ok) state_next = ST_IDLE;
        else if (sq_done) state_next = ST_READ;
      end
      ST_READ: begin
        if (is_read && out_valid && out_stall) state_next = ST_READ;
        else state_next = ST_WRITE;
      end
      ST_WRITE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    sq_start = (state == ST_BIN);
  end

  assign pos  = ang + AW'({half_fov, 6'd0});
  assign prod = {17'd0, pos[AW-1:0]} * {25'd0, bin_scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_READ && is_read && !(out_valid && out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            is_read <= (operation == OP_READ);
            req_bin <= read_bin;
            addr    <= BW'(read_bin);
            addr_ok <= (32'(read_bin) < BIN_COUNT);
            cu      <= CW'(u0) <<< PRE_SHIFT;
            cv      <= CW'(v0) <<< PRE_SHIFT;
            step    <= '0;
            cordic_skip <= (v0 == '0) || (u0 == '0);
            sum_sq  <= 32'(32'(signed'(x_mm)) * 32'(signed'(x_mm)))
                     + 32'(32'(signed'(z_mm)) * 32'(signed'(z_mm)));
            if (v0 == '0) ang <= '0;
            else if (u0 == '0) ang <= (v0 > 0) ? HALF_PI_Q20 : -HALF_PI_Q20;
            else ang <= '0;
          end
        end
        ST_ITER: begin
          if (!cordic_skip) begin
            if (cv >= 0) begin
              cu  <= cu + du;
              cv  <= cv - dv;
              ang <= ang + atan_q20(step);
            end else begin
              cu  <= cu - du;
              cv  <= cv + dv;
              ang <= ang - atan_q20(step);
            end
            step <= step + 5'd1;
          end
        end
        ST_BIN: begin
          addr_ok <= !pos[AW-1] && (prod[40:24] < 17'(BIN_COUNT));
          addr    <= BW'(prod[40:24]);
        end
        ST_SQRT: if (sq_done) range_val <= sq_root;
        ST_READ: begin
          if (is_read && !(out_valid && out_stall)) begin
            bin_range <= addr_ok ? mem_rd : 16'd0;
            bin_echo  <= req_bin;
          end
        end
        default: ;
      endcase
    end
  end

  // x or z zero: the angle is preset at accept and the CORDIC steps are skipped

  // bin memory: one read port, one write port, registered read;
  // while idle the read follows the incoming request so data is ready next cycle
  assign rd_addr = (state == ST_IDLE) ? BW'(read_bin) : addr;

  always_ff @(posedge clk) begin
    mem_rd <= mem[rd_addr];
    if (state == ST_CLEAR) begin
      mem[clr_cnt[BW-1:0]] <= '0;
    end else if (state == ST_WRITE && addr_ok) begin
      if (is_read) mem[addr] <= '0;
      else if (mem_rd < range_val) mem[addr] <= range_val;
    end
  end

  pcarb_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sum_sq),
    .done     (sq_done),
    .root     (sq_root)
  );
endmodule
